/* sv/rlcum_pkg.sv */
// shared types and constants of the unacknowledged-mode transmit segmenter
package rlcum_pkg;

    localparam int unsigned LEN_W   = 16;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned GRANT_W = 16;
    localparam int unsigned SEQ_W   = 12;
    localparam int unsigned HDR_W   = 3;
    localparam int unsigned BS_W    = 21;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [SEQ_W-1:0] SEQ_MASK_6  = 12'h03F;
    localparam logic [SEQ_W-1:0] SEQ_MASK_12 = 12'hFFF;
    localparam logic [BS_W-1:0]  BS_MAX      = 21'h1FFFFF;

    typedef enum logic [2:0] {
        ST_PDU      = 3'd0,
        ST_SMALL    = 3'd1,
        ST_NO_SDU   = 3'd2,
        ST_ACCEPTED = 3'd3,
        ST_DROPPED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SI_FULL   = 2'd0,
        SI_FIRST  = 2'd1,
        SI_LAST   = 2'd2,
        SI_MIDDLE = 2'd3
    } si_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SN_SIZE         = 2'd0,
        CFG_HDR_COMPLETE    = 2'd1,
        CFG_HDR_NO_OFFSET   = 2'd2,
        CFG_HDR_WITH_OFFSET = 2'd3
    } cfg_idx_t;

    localparam logic ACT_ENQUEUE = 1'b0;

    typedef struct packed {
        logic             sn_size_12;
        logic [HDR_W-1:0] hdr_complete;
        logic [HDR_W-1:0] hdr_no_offset;
        logic [HDR_W-1:0] hdr_with_offset;
    } cfg_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic report;
    } cmd_t;

endpackage

/* sv/rlc_um_tx_segmenter.sv */
// top level of the unacknowledged-mode transmit segmenter
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------------
//  command   | start / busy           | action, sdu_size, tag_valid, upper_count,
//            |                        | grant_bytes
//  result    | done (one-cycle pulse) | status, si_code, seq_out, offset_out,
//            |                        | header_length, payload_length, start_notify,
//            |                        | started_count, buffer_state
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// an item goes through latch, segment decision with state update, buffer state sum;
// done pulses once the buffer state sum is registered and busy is low in that cycle,
// so no item is taken before the last is through; the three-state sequencer sets this.
// reset clears the queue count, pointers, active sdu and sequence number; the queue
// memory itself is not cleared. cfg_ready is always high. results cannot be held off.
module rlc_um_tx_segmenter import rlcum_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned LEN_BITS    = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [LEN_W-1:0]      sdu_size,
    input  logic                  tag_valid,
    input  logic [COUNT_W-1:0]    upper_count,
    input  logic [GRANT_W-1:0]    grant_bytes,
    output logic                  done,
    output logic [2:0]            status,
    output logic [1:0]            si_code,
    output logic [SEQ_W-1:0]      seq_out,
    output logic [LEN_W-1:0]      offset_out,
    output logic [HDR_W-1:0]      header_length,
    output logic [LEN_W-1:0]      payload_length,
    output logic                  start_notify,
    output logic [COUNT_W-1:0]    started_count,
    output logic [BS_W-1:0]       buffer_state,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    cmd_t cmd;

    rlcum_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlcum_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rlcum_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEN_BITS    (LEN_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .action         (action),
        .sdu_size       (sdu_size),
        .tag_valid      (tag_valid),
        .upper_count    (upper_count),
        .grant_bytes    (grant_bytes),
        .status         (status),
        .si_code        (si_code),
        .seq_out        (seq_out),
        .offset_out     (offset_out),
        .header_length  (header_length),
        .payload_length (payload_length),
        .start_notify   (start_notify),
        .started_count  (started_count),
        .buffer_state   (buffer_state)
    );

endmodule

/* sv/rlcum_cfg.sv */
// configuration registers of the segmenter
module rlcum_cfg import rlcum_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SN_SIZE:         cfg_next.sn_size_12      = cfg_data[0];
                CFG_HDR_COMPLETE:    cfg_next.hdr_complete    = cfg_data[HDR_W-1:0];
                CFG_HDR_NO_OFFSET:   cfg_next.hdr_no_offset   = cfg_data[HDR_W-1:0];
                CFG_HDR_WITH_OFFSET: cfg_next.hdr_with_offset = cfg_data[HDR_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sn_size_12      <= 1'b0;
            cfg_reg.hdr_complete    <= 3'd1;
            cfg_reg.hdr_no_offset   <= 3'd1;
            cfg_reg.hdr_with_offset <= 3'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/rlcum_ctrl.sv */
// sequencing state machine: latch, decide, report
module rlcum_ctrl import rlcum_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_REPORT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

/* sv/rlcum_dp.sv */
// datapath: sdu queue, active sdu tracking, segment decision and buffer state
module rlcum_dp import rlcum_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned LEN_BITS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  cfg_t               cfg,
    input  logic               action,
    input  logic [LEN_W-1:0]   sdu_size,
    input  logic               tag_valid,
    input  logic [COUNT_W-1:0] upper_count,
    input  logic [GRANT_W-1:0] grant_bytes,
    output logic [2:0]         status,
    output logic [1:0]         si_code,
    output logic [SEQ_W-1:0]   seq_out,
    output logic [LEN_W-1:0]   offset_out,
    output logic [HDR_W-1:0]   header_length,
    output logic [LEN_W-1:0]   payload_length,
    output logic               start_notify,
    output logic [COUNT_W-1:0] started_count,
    output logic [BS_W-1:0]    buffer_state
);

    localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned QB_W   = LEN_W + CNT_W;
    localparam int unsigned SUM_W  = QB_W + 3;
    localparam int unsigned HB_W   = CNT_W + HDR_W;
    localparam int unsigned ENT_W  = LEN_W + 1 + COUNT_W;
    localparam int unsigned KEEP_W = (LEN_BITS >= LEN_W) ? LEN_W : LEN_BITS;
    localparam logic [LEN_W-1:0] LEN_MASK  = {LEN_W{1'b1}} >> (LEN_W - KEEP_W);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

    // queue memory: {length, tag valid, tag}
    logic [ENT_W-1:0] mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;
    logic             wr_en;

    // latched item
    logic               act_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               tagv_reg;
    logic [COUNT_W-1:0] tagc_reg;
    logic [GRANT_W-1:0] grant_reg;

    // block state
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QB_W-1:0]  qbytes_reg, qbytes_next;
    logic             active_reg, active_next;
    logic [LEN_W-1:0] alen_reg,   alen_next;
    logic [LEN_W-1:0] noff_reg,   noff_next;
    logic [SEQ_W-1:0] tx_seq_reg, tx_seq_next;

    // result
    status_t            status_reg,  status_next;
    si_t                si_reg,      si_next;
    logic [SEQ_W-1:0]   seq_reg,     seq_next;
    logic [LEN_W-1:0]   off_reg,     off_next;
    logic [HDR_W-1:0]   hlen_reg,    hlen_next;
    logic [LEN_W-1:0]   pay_reg,     pay_next;
    logic               notify_reg,  notify_next;
    logic [COUNT_W-1:0] started_reg, started_next;
    logic [BS_W-1:0]    bstate_reg,  bstate_next;

    // decision terms
    logic [LEN_W-1:0]   mem_len;
    logic               mem_tagv;
    logic [COUNT_W-1:0] mem_tagc;
    logic               load;
    logic [LEN_W-1:0]   cur_len;
    logic [LEN_W-1:0]   cur_off;
    logic [LEN_W-1:0]   remain;
    logic [GRANT_W-1:0] room_c;
    logic [GRANT_W-1:0] room_w;
    logic [GRANT_W-1:0] space;
    logic               ok;
    logic [SEQ_W-1:0]   seq_mask;

    // buffer state terms
    logic [HB_W-1:0]  hdr_bytes;
    logic [SUM_W-1:0] bs_sum;

    assign mem_len  = rd_data_reg[ENT_W-1 -: LEN_W];
    assign mem_tagv = rd_data_reg[COUNT_W];
    assign mem_tagc = rd_data_reg[COUNT_W-1:0];
    assign seq_mask = cfg.sn_size_12 ? SEQ_MASK_12 : SEQ_MASK_6;

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_ptr_reg] <= {len_reg, tagv_reg, tagc_reg};
        end
        // head entry is re-read every cycle, so it is current when an item starts
        rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg   <= action;
            len_reg   <= sdu_size & LEN_MASK;
            tagv_reg  <= tag_valid;
            tagc_reg  <= upper_count;
            grant_reg <= grant_bytes;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        qbytes_next  = qbytes_reg;
        active_next  = active_reg;
        alen_next    = alen_reg;
        noff_next    = noff_reg;
        tx_seq_next  = tx_seq_reg;
        status_next  = ST_SMALL;
        si_next      = SI_FULL;
        seq_next     = '0;
        off_next     = '0;
        hlen_next    = '0;
        pay_next     = '0;
        notify_next  = 1'b0;
        started_next = '0;
        wr_en        = 1'b0;
        ok           = 1'b1;
        space        = '0;

        load    = !active_reg;
        cur_len = load ? mem_len : alen_reg;
        cur_off = load ? '0 : noff_reg;
        remain  = cur_len - cur_off;
        room_c  = grant_reg - GRANT_W'(cfg.hdr_complete);
        room_w  = grant_reg - GRANT_W'(cfg.hdr_with_offset);

        if (act_reg == ACT_ENQUEUE)
        begin
            if (count_reg == CNT_FULL || len_reg == '0)
            begin
                status_next = ST_DROPPED;
            end
            else
            begin
                wr_en       = 1'b1;
                count_next  = count_reg + 1'b1;
                wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                qbytes_next = qbytes_reg + QB_W'(len_reg);
                status_next = ST_ACCEPTED;
            end
        end
        else if (grant_reg <= GRANT_W'(cfg.hdr_complete))
        begin
            status_next = ST_SMALL;
        end
        else if (load && count_reg == '0)
        begin
            status_next = ST_NO_SDU;
        end
        else
        begin
            if (load)
            begin
                notify_next  = mem_tagv;
                started_next = mem_tagv ? mem_tagc : '0;
                qbytes_next  = qbytes_reg - QB_W'(mem_len);
                count_next   = count_reg - 1'b1;
                rd_ptr_next  = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                active_next  = 1'b1;
                alen_next    = mem_len;
                noff_next    = '0;
            end

            if (cur_off == '0)
            begin
                if (remain <= room_c)
                begin
                    si_next   = SI_FULL;
                    hlen_next = cfg.hdr_complete;
                end
                else if (grant_reg <= GRANT_W'(cfg.hdr_no_offset))
                begin
                    ok = 1'b0;
                end
                else
                begin
                    si_next   = SI_FIRST;
                    hlen_next = cfg.hdr_no_offset;
                end
            end
            else if (grant_reg <= GRANT_W'(cfg.hdr_with_offset))
            begin
                ok = 1'b0;
            end
            else
            begin
                hlen_next = cfg.hdr_with_offset;
                si_next   = (remain <= room_w) ? SI_LAST : SI_MIDDLE;
            end

            if (!ok)
            begin
                // sdu stays loaded, only the pdu is refused
                status_next = ST_SMALL;
                si_next     = SI_FULL;
                hlen_next   = '0;
            end
            else
            begin
                space       = grant_reg - GRANT_W'(hlen_next);
                status_next = ST_PDU;
                pay_next    = (space >= remain) ? remain : space;
                if (si_next != SI_FULL)
                begin
                    seq_next = tx_seq_reg & seq_mask;
                    off_next = cur_off;
                end
                if (si_next == SI_FULL || si_next == SI_LAST)
                begin
                    active_next = 1'b0;
                    alen_next   = '0;
                    noff_next   = '0;
                end
                else
                begin
                    noff_next = cur_off + pay_next;
                end
                if (si_next == SI_LAST)
                begin
                    tx_seq_next = (tx_seq_reg + 1'b1) & seq_mask;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            qbytes_reg <= '0;
            active_reg <= 1'b0;
            alen_reg   <= '0;
            noff_reg   <= '0;
            tx_seq_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            qbytes_reg <= qbytes_next;
            active_reg <= active_next;
            alen_reg   <= alen_next;
            noff_reg   <= noff_next;
            tx_seq_reg <= tx_seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            si_reg      <= si_next;
            seq_reg     <= seq_next;
            off_reg     <= off_next;
            hlen_reg    <= hlen_next;
            pay_reg     <= pay_next;
            notify_reg  <= notify_next;
            started_reg <= started_next;
        end
        if (cmd.report)
        begin
            bstate_reg <= bstate_next;
        end
    end

    // buffer state from the state left by the decision
    always_comb
    begin
        hdr_bytes = HB_W'(count_reg) * HB_W'(cfg.hdr_complete);
        bs_sum    = SUM_W'(qbytes_reg) + SUM_W'(hdr_bytes);
        if (active_reg)
        begin
            bs_sum = bs_sum + SUM_W'(alen_reg - noff_reg) + SUM_W'(cfg.hdr_with_offset);
        end
        bstate_next = (bs_sum > SUM_W'(BS_MAX)) ? BS_MAX : bs_sum[BS_W-1:0];
    end

    assign status         = status_reg;
    assign si_code        = si_reg;
    assign seq_out        = seq_reg;
    assign offset_out     = off_reg;
    assign header_length  = hlen_reg;
    assign payload_length = pay_reg;
    assign start_notify   = notify_reg;
    assign started_count  = started_reg;
    assign buffer_state   = bstate_reg;

endmodule

/* sv/rlcum_checker.sv */
// port-level checks of the segmenter, bound to the top level
module rlcum_checker import rlcum_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [2:0]         status,
    input logic [1:0]         si_code,
    input logic [HDR_W-1:0]   header_length,
    input logic [LEN_W-1:0]   payload_length,
    input logic               start_notify,
    input logic [COUNT_W-1:0] started_count
);

    logic accept;

    assign accept = start && !busy;

    // an accepted beat makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted beat");

    // every accepted beat is followed by its result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("result strobe missing three cycles after accept");

    // result strobe is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // only a built pdu carries segment fields
    a_unused_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_PDU) |->
            (si_code == SI_FULL && header_length == '0 && payload_length == '0))
        else $error("segment fields set on a result without a pdu");

    a_started_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !start_notify) |-> (started_count == '0))
        else $error("started count set without start notify");

endmodule

bind rlc_um_tx_segmenter rlcum_checker u_rlcum_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .si_code        (si_code),
    .header_length  (header_length),
    .payload_length (payload_length),
    .start_notify   (start_notify),
    .started_count  (started_count)
);

/* bench/tb_rlc_um_tx_segmenter.sv */
// self-checking bench for the transmit segmenter, scoreboard against a local predictor
module tb_rlc_um_tx_segmenter import rlcum_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_N       = 22;
    localparam logic ACT_GRANT = 1'b1;

    typedef struct packed {
        logic               act;
        logic [LEN_W-1:0]   len;
        logic               tagv;
        logic [COUNT_W-1:0] cnt;
        logic [GRANT_W-1:0] grant;
    } sdu_cmd_t;

    typedef struct packed {
        status_t            status;
        si_t                si;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   off;
        logic [HDR_W-1:0]   hlen;
        logic [LEN_W-1:0]   pay;
        logic               notify;
        logic [COUNT_W-1:0] started;
        logic [BS_W-1:0]    bs;
    } seg_result_t;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [4:0]      reps;
        sdu_cmd_t        cmd;
        cfg_idx_t        reg_idx;
        logic [7:0]      reg_val;
        logic            typed;
        seg_result_t     want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  action = 1'b0;
    logic [LEN_W-1:0]      sdu_size = '0;
    logic                  tag_valid = 1'b0;
    logic [COUNT_W-1:0]    upper_count = '0;
    logic [GRANT_W-1:0]    grant_bytes = '0;
    logic                  done;
    logic [2:0]            status;
    logic [1:0]            si_code;
    logic [SEQ_W-1:0]      seq_out;
    logic [LEN_W-1:0]      offset_out;
    logic [HDR_W-1:0]      header_length;
    logic [LEN_W-1:0]      payload_length;
    logic                  start_notify;
    logic [COUNT_W-1:0]    started_count;
    logic [BS_W-1:0]       buffer_state;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    cfg_t              seg_cfg = '{sn_size_12: 1'b0, hdr_complete: 3'd1,
                                   hdr_no_offset: 3'd1, hdr_with_offset: 3'd3};
    logic [LEN_W-1:0]  q_len [QDEPTH];
    logic [32:0]       q_tag [QDEPTH];
    int unsigned       q_fill = 0;
    int unsigned       q_head = 0;
    longint unsigned   q_bytes = 0;
    bit                sdu_open = 1'b0;
    int unsigned       sdu_len = 0;
    int unsigned       sdu_off = 0;
    logic [SEQ_W-1:0]  next_sn = '0;

    seg_result_t       pending [$];
    int                errors = 0;
    int unsigned       cycle_cnt = 0;
    dir_row_t          dir_rows [DIR_N];

    rlc_um_tx_segmenter #(
        .QUEUE_DEPTH (QDEPTH),
        .LEN_BITS    (LEN_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .sdu_size       (sdu_size),
        .tag_valid      (tag_valid),
        .upper_count    (upper_count),
        .grant_bytes    (grant_bytes),
        .done           (done),
        .status         (status),
        .si_code        (si_code),
        .seq_out        (seq_out),
        .offset_out     (offset_out),
        .header_length  (header_length),
        .payload_length (payload_length),
        .start_notify   (start_notify),
        .started_count  (started_count),
        .buffer_state   (buffer_state),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // works out the result of one command and moves the predicted queue and sdu state
    function automatic seg_result_t segment_step(sdu_cmd_t c);
        seg_result_t     r;
        int unsigned     grant;
        int unsigned     hc;
        int unsigned     hn;
        int unsigned     hw;
        int unsigned     slot;
        int unsigned     remain;
        int unsigned     space;
        logic [SEQ_W-1:0] sn_mask;
        bit              fits;
        longint unsigned level;
        r = '0;
        grant = c.grant;
        hc = seg_cfg.hdr_complete;
        hn = seg_cfg.hdr_no_offset;
        hw = seg_cfg.hdr_with_offset;
        sn_mask = seg_cfg.sn_size_12 ? SEQ_MASK_12 : SEQ_MASK_6;
        if (c.act == ACT_ENQUEUE)
        begin
            if (q_fill >= QDEPTH || c.len == 0)
                r.status = ST_DROPPED;
            else
            begin
                slot = (q_head + q_fill) % QDEPTH;
                q_len[slot] = c.len;
                q_tag[slot] = {c.tagv, c.cnt};
                q_fill++;
                q_bytes += c.len;
                r.status = ST_ACCEPTED;
            end
        end
        else if (grant <= hc)
            r.status = ST_SMALL;
        else if (!sdu_open && q_fill == 0)
            r.status = ST_NO_SDU;
        else
        begin
            if (!sdu_open)
            begin
                sdu_len = q_len[q_head];
                sdu_off = 0;
                sdu_open = 1'b1;
                if (q_tag[q_head][32])
                begin
                    r.notify = 1'b1;
                    r.started = q_tag[q_head][31:0];
                end
                q_bytes -= sdu_len;
                q_fill--;
                q_head = (q_head + 1) % QDEPTH;
            end
            remain = sdu_len - sdu_off;
            fits = 1'b1;
            if (sdu_off == 0)
            begin
                if (remain <= grant - hc)
                begin
                    r.si = SI_FULL;
                    r.hlen = HDR_W'(hc);
                end
                else if (grant <= hn)
                    fits = 1'b0;
                else
                begin
                    r.si = SI_FIRST;
                    r.hlen = HDR_W'(hn);
                end
            end
            else if (grant <= hw)
                fits = 1'b0;
            else
            begin
                r.hlen = HDR_W'(hw);
                r.si = (remain <= grant - hw) ? SI_LAST : SI_MIDDLE;
            end
            if (!fits)
            begin
                // sdu stays loaded, the start report still goes out
                r.status = ST_SMALL;
                r.si = SI_FULL;
                r.hlen = '0;
            end
            else
            begin
                space = grant - r.hlen;
                r.status = ST_PDU;
                r.pay = (space >= remain) ? LEN_W'(remain) : LEN_W'(space);
                if (r.si != SI_FULL)
                begin
                    r.seq = next_sn & sn_mask;
                    r.off = LEN_W'(sdu_off);
                end
                if (r.si == SI_FULL || r.si == SI_LAST)
                begin
                    sdu_open = 1'b0;
                    sdu_len = 0;
                    sdu_off = 0;
                end
                else
                    sdu_off += r.pay;
                if (r.si == SI_LAST)
                    next_sn = (next_sn + 1'b1) & sn_mask;
            end
        end
        level = q_bytes + longint'(q_fill) * hc;
        if (sdu_open)
            level += (sdu_len - sdu_off) + hw;
        r.bs = (level > BS_MAX) ? BS_MAX : BS_W'(level);
        return r;
    endfunction

    function automatic sdu_cmd_t random_cmd();
        sdu_cmd_t    c;
        int unsigned pick;
        c.act = ($urandom_range(99) < 45) ? ACT_ENQUEUE : ACT_GRANT;
        pick = $urandom_range(99);
        if (pick < 2)
            c.len = '0;
        else if (pick < 6)
            c.len = LEN_W'($urandom_range(65535, 1));
        else
            c.len = LEN_W'($urandom_range(300, 1));
        c.tagv = 1'($urandom_range(1));
        c.cnt = $urandom;
        pick = $urandom_range(99);
        if (pick < 20)
            c.grant = GRANT_W'($urandom_range(12));
        else if (pick < 85)
            c.grant = GRANT_W'($urandom_range(400, 13));
        else
            c.grant = GRANT_W'($urandom_range(65535, 401));
        return c;
    endfunction

    function automatic seg_result_t res(status_t st, si_t si, int seq, int off, int hlen,
                                        int pay, logic nt, logic [31:0] cnt, int bs);
        seg_result_t r;
        r.status = st;
        r.si = si;
        r.seq = SEQ_W'(seq);
        r.off = LEN_W'(off);
        r.hlen = HDR_W'(hlen);
        r.pay = LEN_W'(pay);
        r.notify = nt;
        r.started = cnt;
        r.bs = BS_W'(bs);
        return r;
    endfunction

    function automatic dir_row_t enq_row(logic [LEN_W-1:0] len, logic tv, logic [31:0] cnt,
                                         int reps);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CMD;
        row.reps = 5'(reps);
        row.cmd = '{act: ACT_ENQUEUE, len: len, tagv: tv, cnt: cnt, grant: '0};
        return row;
    endfunction

    function automatic dir_row_t grant_row(logic [GRANT_W-1:0] g);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CMD;
        row.reps = 5'd1;
        row.cmd = '{act: ACT_GRANT, len: '0, tagv: 1'b0, cnt: '0, grant: g};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(cfg_idx_t idx, logic [7:0] val);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic dir_row_t typed_row(dir_row_t row, seg_result_t want);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    // command beat; start is left high so back-to-back beats need no second assignment
    task automatic send_cmd(sdu_cmd_t c, logic typed, seg_result_t want);
        seg_result_t predicted;
        start <= 1'b1;
        action <= c.act;
        sdu_size <= c.len;
        tag_valid <= c.tagv;
        upper_count <= c.cnt;
        grant_bytes <= c.grant;
        do @(posedge clk); while (busy);
        predicted = segment_step(c);
        pending.insert(pending.size(), typed ? want : predicted);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (pending.size() != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SN_SIZE:         seg_cfg.sn_size_12 = val[0];
            CFG_HDR_COMPLETE:    seg_cfg.hdr_complete = val[HDR_W-1:0];
            CFG_HDR_NO_OFFSET:   seg_cfg.hdr_no_offset = val[HDR_W-1:0];
            CFG_HDR_WITH_OFFSET: seg_cfg.hdr_with_offset = val[HDR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(int idle_pct, int count, logic [7:0] sn_val, logic [7:0] hc_val,
                             logic [7:0] hn_val, logic [7:0] hw_val);
        int n;
        drain_results();
        write_reg(CFG_SN_SIZE, sn_val);
        write_reg(CFG_HDR_COMPLETE, hc_val);
        write_reg(CFG_HDR_NO_OFFSET, hn_val);
        write_reg(CFG_HDR_WITH_OFFSET, hw_val);
        cfg_valid <= 1'b0;
        for (n = 0; n < count; n++)
        begin
            send_cmd(random_cmd(), 1'b0, '0);
            if ($urandom_range(199) == 0)
                drain_results();
            else if ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge clk);
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        seg_result_t want;
        if (rst_n && done)
        begin
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected, expected none, got status %0d",
                         $time, status);
            end
            else
            begin
                want = pending.pop_front();
                check_field("status", want.status, status);
                check_field("si_code", want.si, si_code);
                check_field("seq_out", want.seq, seq_out);
                check_field("offset_out", want.off, offset_out);
                check_field("header_length", want.hlen, header_length);
                check_field("payload_length", want.pay, payload_length);
                check_field("start_notify", want.notify, start_notify);
                check_field("started_count", want.started, started_count);
                check_field("buffer_state", want.bs, buffer_state);
            end
        end
    end

    initial
    begin
        int i;
        int k;
        dir_rows = '{
            typed_row(grant_row(16'd0), res(ST_SMALL, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 0)),
            typed_row(grant_row(16'hFFFF), res(ST_NO_SDU, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 0)),
            typed_row(enq_row(16'd0, 1'b1, 32'hFFFF_FFFF, 1),
                      res(ST_DROPPED, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 0)),
            typed_row(enq_row(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1),
                      res(ST_ACCEPTED, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 65536)),
            typed_row(grant_row(16'hFFFF),
                      res(ST_PDU, SI_FIRST, 0, 0, 1, 65534, 1'b1, 32'hFFFF_FFFF, 4)),
            typed_row(grant_row(16'd3), res(ST_SMALL, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 4)),
            typed_row(grant_row(16'd4), res(ST_PDU, SI_LAST, 0, 65534, 3, 1, 1'b0, 32'd0, 0)),
            typed_row(enq_row(16'd1, 1'b0, 32'd0, 1),
                      res(ST_ACCEPTED, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 2)),
            typed_row(grant_row(16'd2), res(ST_PDU, SI_FULL, 0, 0, 1, 1, 1'b0, 32'd0, 0)),
            // fill the queue, then one more is dropped
            enq_row(16'd100, 1'b1, 32'h5A5A_0001, 16),
            typed_row(enq_row(16'd7, 1'b0, 32'd0, 1),
                      res(ST_DROPPED, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 1616)),
            typed_row(grant_row(16'd1), res(ST_SMALL, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 1616)),
            // grant passes the entry check but not the first-segment header
            cfg_row(CFG_HDR_NO_OFFSET, 8'h04),
            grant_row(16'd3),
            grant_row(16'd200),
            cfg_row(CFG_SN_SIZE, 8'hFF),
            cfg_row(CFG_HDR_WITH_OFFSET, 8'hF8),
            grant_row(16'd50),
            grant_row(16'd30),
            grant_row(16'd40),
            cfg_row(CFG_HDR_COMPLETE, 8'h07),
            typed_row(grant_row(16'd7), res(ST_SMALL, SI_FULL, 0, 0, 0, 0, 1'b0, 32'd0, 1498))
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
                cfg_valid <= 1'b0;
            end
            else
            begin
                for (k = 0; k < dir_rows[i].reps; k++)
                    send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // smallest headers with 12-bit numbering, then largest with 6-bit mid-stream
        run_phase(15, 250, 8'h01, 8'h01, 8'h01, 8'h01);
        run_phase(84, 150, 8'hFE, 8'h04, 8'h04, 8'h06);
        run_phase(0, 200, 8'hFF, 8'hF2, 8'h0B, 8'h05);

        drain_results();
        repeat (6) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
